### rtl/indexed_list_table_core_defines.svh
// Assertion macros for the indexed list table core.
// Used by the checker that is bound to the top level; no other dependencies.
`ifndef INDEXED_LIST_TABLE_CORE_DEFINES_SVH
`define INDEXED_LIST_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define ILT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ILT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ilt_pkg.sv
// Package for the indexed list table: field widths, request and status codes,
// sequencer states and the request and response structs. No dependencies.
`timescale 1ns / 1ps

package ilt_pkg;

    localparam int DEPTH_DEF  = 64;
    localparam int ELEM_W_DEF = 32;

    localparam int REQ_W     = 3;
    localparam int POS_W     = 7;
    localparam int ELEM_IN_W = 32;
    localparam int DATA_W    = 32;
    localparam int STATUS_W  = 3;
    localparam int COUNT_W   = 7;

    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND = 3'd0,
        REQ_INSERT = 3'd1,
        REQ_SET    = 3'd2,
        REQ_GET    = 3'd3,
        REQ_REMOVE = 3'd4,
        REQ_FIND   = 3'd5,
        REQ_CLEAR  = 3'd6
    } t_req_code;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_INDEX = 3'd1,
        ST_NULL      = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_GET_WAIT,
        S_RM_DATA,
        S_SHUP_RD,
        S_SHUP_WR,
        S_SHDN_RD,
        S_SHDN_WR,
        S_FIND_RD,
        S_FIND_CMP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [REQ_W-1:0]     req_type;
        logic [POS_W-1:0]     position;
        logic [ELEM_IN_W-1:0] element;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic [DATA_W-1:0]  data;
        logic [COUNT_W-1:0] count;
        logic               is_empty;
    } t_rsp;

endpackage

### rtl/ilt_if.sv
// Request and response channel interfaces of the indexed list table.
// Depends on ilt_pkg for the field widths.
`timescale 1ns / 1ps

interface ilt_req_if;
    import ilt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [REQ_W-1:0]     req_type;
    logic [POS_W-1:0]     position;
    logic [ELEM_IN_W-1:0] element;

    modport source (output valid, req_type, position, element, input ready);
    modport sink   (input valid, req_type, position, element, output ready);
endinterface

interface ilt_rsp_if;
    import ilt_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   data;
    logic [COUNT_W-1:0]  count;
    logic                is_empty;

    modport source (output valid, status, data, count, is_empty, input ready);
    modport sink   (input valid, status, data, count, is_empty, output ready);
endinterface

### rtl/indexed_list_table_core.sv
// Top level of the indexed list table: channel interfaces, sequencer, entry
// RAM and the response output register. Depends on ilt_pkg, ilt_if, ilt_seq
// and ilt_ram.
//
// Requests arrive on i_req and each gives exactly one beat on o_rsp, in order.
// One request is in work at a time: i_req.ready is high only while the
// sequencer is idle. Append, set, clear and every rejected request finish in
// the decode state; get waits for the registered RAM read; insert, remove and
// find walk the entries one by one. The longest requests are set by the single
// read port of the entry RAM, which the shared index adder walks one entry at
// a time, with a read state and then a write or compare state per entry.
// i_req.ready returns at the same edge that registers the response.
// The response register frees the sequencer, so a new request can be
// accepted while the previous response beat is still stalled; a second
// response then waits in the sequencer until o_rsp.ready takes the first.
// Reset empties the list at once; entry contents are not cleared and need no
// clearing pass, as only written entries are ever read.
`timescale 1ns / 1ps

module indexed_list_table_core #(
    parameter int DEPTH  = ilt_pkg::DEPTH_DEF,
    parameter int ELEM_W = ilt_pkg::ELEM_W_DEF
) (
    input logic         i_clk,
    input logic         i_rst_n,
    ilt_req_if.sink     i_req,
    ilt_rsp_if.source   o_rsp
);
    import ilt_pkg::*;

    localparam int AW = $clog2(DEPTH);

    t_req              w_req;
    t_rsp              w_seq_rsp;
    logic              w_idle, w_done, w_rsp_ready;
    logic              w_we;
    logic [AW-1:0]     w_waddr, w_raddr;
    logic [ELEM_W-1:0] w_wdata, w_rdata;

    logic r_out_valid, n_out_valid;
    t_rsp r_out;

    assign w_req.req_type = i_req.req_type;
    assign w_req.position = i_req.position;
    assign w_req.element  = i_req.element;

    ilt_seq #(
        .DEPTH  (DEPTH),
        .ELEM_W (ELEM_W)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_req.valid && w_idle),
        .i_req       (w_req),
        .o_idle      (w_idle),
        .o_done      (w_done),
        .o_rsp       (w_seq_rsp),
        .i_rsp_ready (w_rsp_ready),
        .o_we        (w_we),
        .o_waddr     (w_waddr),
        .o_wdata     (w_wdata),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata)
    );

    ilt_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rsp_ready = !r_out_valid || o_rsp.ready;

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_done && w_rsp_ready) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done && w_rsp_ready) begin
            r_out <= w_seq_rsp;
        end
    end

    assign i_req.ready    = w_idle;
    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.status   = r_out.status;
    assign o_rsp.data     = r_out.data;
    assign o_rsp.count    = r_out.count;
    assign o_rsp.is_empty = r_out.is_empty;
endmodule

### rtl/ilt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module ilt_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 64,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/ilt_seq.sv
// Sequencer of the indexed list table: request decode, count register and the
// shared index adder that walks the entry RAM. Depends on ilt_pkg.
`timescale 1ns / 1ps

module ilt_seq #(
    parameter int  DEPTH  = ilt_pkg::DEPTH_DEF,
    parameter int  ELEM_W = ilt_pkg::ELEM_W_DEF,
    localparam int AW     = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  ilt_pkg::t_req     i_req,
    output logic              o_idle,
    output logic              o_done,
    output ilt_pkg::t_rsp     o_rsp,
    input  logic              i_rsp_ready,
    output logic              o_we,
    output logic [AW-1:0]     o_waddr,
    output logic [ELEM_W-1:0] o_wdata,
    output logic [AW-1:0]     o_raddr,
    input  logic [ELEM_W-1:0] i_rdata
);
    import ilt_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > POS_W) ? CW : POS_W;

    t_state              r_state, n_state;
    logic [REQ_W-1:0]    r_req_type, n_req_type;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [ELEM_W-1:0]   r_elem, n_elem;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_idx, n_idx;
    t_status             r_status, n_status;
    logic [DATA_W-1:0]   r_data, n_data;

    logic [LW-1:0] w_pos_l, w_cnt_l, w_idx_l, w_sum_l;
    logic [CW-1:0] w_pos_c;
    logic [CW-1:0] w_sum;
    logic          w_dec;
    logic          w_null, w_full, w_pos_le, w_pos_lt, w_match;

    assign w_pos_l  = LW'(r_pos);
    assign w_cnt_l  = LW'(r_count);
    assign w_idx_l  = LW'(r_idx);
    assign w_pos_c  = CW'(r_pos);
    assign w_null   = (r_elem == '0);
    assign w_full   = (r_count == CW'(DEPTH));
    assign w_pos_le = (w_pos_l <= w_cnt_l);
    assign w_pos_lt = (w_pos_l < w_cnt_l);
    assign w_match  = (i_rdata == r_elem);

    // The one index adder steps down while opening a gap and up otherwise.
    assign w_dec   = (r_state == S_SHUP_RD) || (r_state == S_SHUP_WR);
    assign w_sum   = w_dec ? (r_idx - CW'(1)) : (r_idx + CW'(1));
    assign w_sum_l = LW'(w_sum);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (r_req_type)
                    REQ_INSERT: begin
                        n_state = (!w_null && w_pos_le && !w_full) ? S_SHUP_RD : S_DONE;
                    end
                    REQ_GET:    n_state = w_pos_lt ? S_GET_WAIT : S_DONE;
                    REQ_REMOVE: n_state = w_pos_lt ? S_RM_DATA : S_DONE;
                    REQ_FIND:   n_state = w_null ? S_DONE : S_FIND_RD;
                    default:    n_state = S_DONE;
                endcase
            end
            S_GET_WAIT: n_state = S_DONE;
            S_RM_DATA:  n_state = S_SHDN_RD;
            S_SHUP_RD:  n_state = (w_idx_l == w_pos_l) ? S_DONE : S_SHUP_WR;
            S_SHUP_WR:  n_state = S_SHUP_RD;
            S_SHDN_RD:  n_state = (w_sum_l >= w_cnt_l) ? S_DONE : S_SHDN_WR;
            S_SHDN_WR:  n_state = S_SHDN_RD;
            S_FIND_RD:  n_state = (w_idx_l >= w_cnt_l) ? S_DONE : S_FIND_CMP;
            S_FIND_CMP: n_state = w_match ? S_DONE : S_FIND_RD;
            S_DONE: begin
                if (i_rsp_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_req_type = r_req_type;
        n_pos      = r_pos;
        n_elem     = r_elem;
        n_count    = r_count;
        n_idx      = r_idx;
        n_status   = r_status;
        n_data     = r_data;
        o_we       = 1'b0;
        o_waddr    = AW'(r_idx);
        o_wdata    = r_elem;
        o_raddr    = AW'(r_idx);
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req_type = i_req.req_type;
                    n_pos      = i_req.position;
                    n_elem     = ELEM_W'(i_req.element);
                    n_status   = ST_OK;
                    n_data     = '0;
                end
            end
            S_DECODE: begin
                case (r_req_type)
                    REQ_APPEND: begin
                        if (w_null) begin
                            n_status = ST_NULL;
                        end else if (w_full) begin
                            n_status = ST_FULL;
                        end else begin
                            o_we    = 1'b1;
                            o_waddr = AW'(r_count);
                            n_count = r_count + CW'(1);
                        end
                    end
                    REQ_INSERT: begin
                        if (w_null) begin
                            n_status = ST_NULL;
                        end else if (!w_pos_le) begin
                            n_status = ST_BAD_INDEX;
                        end else if (w_full) begin
                            n_status = ST_FULL;
                        end else begin
                            n_idx = r_count;
                        end
                    end
                    REQ_SET: begin
                        if (w_null) begin
                            n_status = ST_NULL;
                        end else if (!w_pos_lt) begin
                            n_status = ST_BAD_INDEX;
                        end else begin
                            o_we    = 1'b1;
                            o_waddr = AW'(w_pos_c);
                        end
                    end
                    REQ_GET: begin
                        if (!w_pos_lt) begin
                            n_status = ST_BAD_INDEX;
                        end else begin
                            o_raddr = AW'(w_pos_c);
                        end
                    end
                    REQ_REMOVE: begin
                        if (!w_pos_lt) begin
                            n_status = ST_BAD_INDEX;
                        end else begin
                            o_raddr = AW'(w_pos_c);
                            n_idx   = w_pos_c;
                        end
                    end
                    REQ_FIND: begin
                        if (w_null) begin
                            n_status = ST_NULL;
                        end else begin
                            n_idx = '0;
                        end
                    end
                    REQ_CLEAR: begin
                        n_count = '0;
                    end
                    default: begin
                        n_status = ST_OK;
                    end
                endcase
            end
            S_GET_WAIT: begin
                n_data = DATA_W'(i_rdata);
            end
            S_RM_DATA: begin
                n_data = DATA_W'(i_rdata);
            end
            S_SHUP_RD: begin
                if (w_idx_l == w_pos_l) begin
                    o_we    = 1'b1;
                    n_count = r_count + CW'(1);
                end else begin
                    o_raddr = AW'(w_sum);
                end
            end
            S_SHUP_WR: begin
                o_we    = 1'b1;
                o_wdata = i_rdata;
                n_idx   = w_sum;
            end
            S_SHDN_RD: begin
                if (w_sum_l >= w_cnt_l) begin
                    n_count = r_count - CW'(1);
                end else begin
                    o_raddr = AW'(w_sum);
                end
            end
            S_SHDN_WR: begin
                o_we    = 1'b1;
                o_wdata = i_rdata;
                n_idx   = w_sum;
            end
            S_FIND_RD: begin
                if (w_idx_l >= w_cnt_l) begin
                    n_status = ST_NOT_FOUND;
                end
            end
            S_FIND_CMP: begin
                if (w_match) begin
                    n_data = DATA_W'(r_idx);
                end else begin
                    n_idx = w_sum;
                end
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req_type <= n_req_type;
        r_pos      <= n_pos;
        r_elem     <= n_elem;
        r_idx      <= n_idx;
        r_status   <= n_status;
        r_data     <= n_data;
    end

    assign o_idle         = (r_state == S_IDLE);
    assign o_done         = (r_state == S_DONE);
    assign o_rsp.status   = r_status;
    assign o_rsp.data     = r_data;
    assign o_rsp.count    = COUNT_W'(r_count);
    assign o_rsp.is_empty = (r_count == '0);
endmodule

### rtl/ilt_checker.sv
// Port-level checker for the indexed list table and its bind to the top level.
// Depends on ilt_pkg and indexed_list_table_core_defines.svh.
`timescale 1ns / 1ps
`include "indexed_list_table_core_defines.svh"

module ilt_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_req_valid,
    input logic                         i_req_ready,
    input logic                         i_rsp_valid,
    input logic                         i_rsp_ready,
    input logic [ilt_pkg::STATUS_W-1:0] i_rsp_status,
    input logic [ilt_pkg::DATA_W-1:0]   i_rsp_data,
    input logic [ilt_pkg::COUNT_W-1:0]  i_rsp_count,
    input logic                         i_rsp_is_empty
);
    import ilt_pkg::*;

    // A stalled response beat keeps its contents.
    `ILT_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_data) && $stable(i_rsp_count), "stalled response beat changed")

    // Only one request is in work: ready drops after every accepted beat.
    `ILT_ASSERT_NEXT(a_one_in_work, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready, "request accepted while another is in work")

    // An empty list always reports a count of zero.
    `ILT_ASSERT_NOW(a_empty_count, i_clk, i_rst_n, i_rsp_valid && i_rsp_is_empty, i_rsp_count == '0, "empty flag with non-zero count")

    // A failed search returns no index.
    `ILT_ASSERT_NOW(a_miss_data, i_clk, i_rst_n, i_rsp_valid && (i_rsp_status == ST_NOT_FOUND), i_rsp_data == '0, "failed search with non-zero data")
endmodule

bind indexed_list_table_core ilt_checker u_ilt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_rsp_status   (o_rsp.status),
    .i_rsp_data     (o_rsp.data),
    .i_rsp_count    (o_rsp.count),
    .i_rsp_is_empty (o_rsp.is_empty)
);

### tb/indexed_list_table_core_tb.sv
// Self-checking testbench for indexed_list_table_core: directed corner requests,
// then random request mixes under varying back-pressure, checked by a scoreboard.
// Depends on ilt_pkg, ilt_if and the core RTL.
`timescale 1ns / 1ps

module indexed_list_table_core_tb;
    import ilt_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;
    localparam int LIST_DEPTH      = DEPTH_DEF;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 2 * LIST_DEPTH + 12;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int BLOCK_ITEMS     = 160;

    class list_table_scoreboard;
        logic [DATA_W-1:0] slots [LIST_DEPTH];
        int                fill;
        t_rsp              expected_rsp [$];
        int                mismatches;

        function new();
            fill = 0;
            mismatches = 0;
            foreach (slots[k]) slots[k] = '0;
        endfunction

        function void note_request(logic [REQ_W-1:0] code, logic [POS_W-1:0] pos,
                                   logic [ELEM_IN_W-1:0] elem);
            t_rsp    r;
            t_status st;
            int      k;
            st = ST_OK;
            r.data = '0;
            case (code)
                REQ_APPEND: begin
                    if (elem == 0) st = ST_NULL;
                    else if (fill >= LIST_DEPTH) st = ST_FULL;
                    else begin
                        slots[fill] = elem;
                        fill++;
                    end
                end
                REQ_INSERT: begin
                    if (elem == 0) st = ST_NULL;
                    else if (int'(pos) > fill) st = ST_BAD_INDEX;
                    else if (fill >= LIST_DEPTH) st = ST_FULL;
                    else begin
                        for (k = fill; k > int'(pos); k--) slots[k] = slots[k-1];
                        slots[pos] = elem;
                        fill++;
                    end
                end
                REQ_SET: begin
                    if (elem == 0) st = ST_NULL;
                    else if (int'(pos) >= fill) st = ST_BAD_INDEX;
                    else slots[pos] = elem;
                end
                REQ_GET: begin
                    if (int'(pos) >= fill) st = ST_BAD_INDEX;
                    else r.data = slots[pos];
                end
                REQ_REMOVE: begin
                    if (int'(pos) >= fill) st = ST_BAD_INDEX;
                    else begin
                        r.data = slots[pos];
                        for (k = int'(pos); k + 1 < fill; k++) slots[k] = slots[k+1];
                        fill--;
                    end
                end
                REQ_FIND: begin
                    if (elem == 0) st = ST_NULL;
                    else begin
                        st = ST_NOT_FOUND;
                        for (k = 0; k < fill; k++) begin
                            if (st == ST_NOT_FOUND && slots[k] == elem) begin
                                st = ST_OK;
                                r.data = k;
                            end
                        end
                    end
                end
                REQ_CLEAR: fill = 0;
                default: ;
            endcase
            r.status = st;
            r.count = fill[COUNT_W-1:0];
            r.is_empty = (fill == 0);
            expected_rsp.push_back(r);
        endfunction

        function void check_response(logic [STATUS_W-1:0] status, logic [DATA_W-1:0] data,
                                     logic [COUNT_W-1:0] count, logic empty_flag);
            t_rsp want;
            if (expected_rsp.size() == 0) begin
                $error("Response beat with no request outstanding.");
                mismatches++;
                return;
            end
            want = expected_rsp.pop_front();
            if (status !== want.status) begin
                $error("status mismatch: expected %0d, got %0d", want.status, status);
                mismatches++;
            end
            if (data !== want.data) begin
                $error("data mismatch: expected 0x%08h, got 0x%08h", want.data, data);
                mismatches++;
            end
            if (count !== want.count) begin
                $error("count mismatch: expected %0d, got %0d", want.count, count);
                mismatches++;
            end
            if (empty_flag !== want.is_empty) begin
                $error("is_empty mismatch: expected %0b, got %0b", want.is_empty, empty_flag);
                mismatches++;
            end
        endfunction

        function int total_failures();
            if (expected_rsp.size() != 0) begin
                $error("%0d responses never arrived.", expected_rsp.size());
                mismatches++;
            end
            return mismatches;
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    ilt_req_if req_ch ();
    ilt_rsp_if rsp_ch ();

    list_table_scoreboard sb = new();

    int send_idle_pct;
    int rcv_idle_pct;
    bit hold_off_req;
    int items_sent;

    indexed_list_table_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic send_request(logic [REQ_W-1:0] code, logic [POS_W-1:0] pos,
                                logic [ELEM_IN_W-1:0] elem);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= code;
        req_ch.position <= pos;
        req_ch.element  <= elem;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) @(posedge i_clk);
        sb.note_request(code, pos, elem);
        items_sent++;
    endtask

    function automatic logic [ELEM_IN_W-1:0] pick_element();
        int u;
        u = $urandom_range(19);
        if (u == 0) return '0;
        if (u == 1) return '1;
        if (u < 10) return $urandom;
        return $urandom_range(1, 48);
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        int u;
        u = $urandom_range(9);
        if (u == 0) return POS_W'($urandom_range(0, 127));
        if (u == 1) return POS_W'(sb.fill);
        return POS_W'($urandom_range(0, sb.fill > 0 ? sb.fill - 1 : 0));
    endfunction

    task automatic send_random_request(bit grow);
        logic [REQ_W-1:0]     code;
        logic [ELEM_IN_W-1:0] elem;
        int                   u;
        u = $urandom_range(99);
        if ($urandom_range(299) == 0) code = REQ_CLEAR;
        else if (grow) begin
            if (u < 40) code = REQ_APPEND;
            else if (u < 60) code = REQ_INSERT;
            else if (u < 68) code = REQ_SET;
            else if (u < 76) code = REQ_GET;
            else if (u < 84) code = REQ_REMOVE;
            else if (u < 97) code = REQ_FIND;
            else code = REQ_UNUSED;
        end else begin
            if (u < 10) code = REQ_APPEND;
            else if (u < 20) code = REQ_INSERT;
            else if (u < 30) code = REQ_SET;
            else if (u < 45) code = REQ_GET;
            else if (u < 85) code = REQ_REMOVE;
            else if (u < 97) code = REQ_FIND;
            else code = REQ_UNUSED;
        end
        elem = pick_element();
        if (code == REQ_FIND && sb.fill > 0 && $urandom_range(1) == 1)
            elem = sb.slots[$urandom_range(0, sb.fill - 1)];
        send_request(code, pick_position(), elem);
    endtask

    task automatic run_random(int items, int s_pct, int r_pct, bit with_hold_off);
        int n;
        send_idle_pct = s_pct;
        rcv_idle_pct = r_pct;
        for (n = 0; n < items; n++) begin
            if (with_hold_off && n == 50) hold_off_req = 1'b1;
            send_random_request(((items_sent / BLOCK_ITEMS) % 2) == 0);
        end
    endtask

    // Receiver: checks each accepted response beat and drives ready.
    initial begin
        int hold_left;
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
                sb.check_response(rsp_ch.status, rsp_ch.data, rsp_ch.count, rsp_ch.is_empty);
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Timeout: no beat accepted for %0d cycles.", STALL_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        send_idle_pct = 21;
        rcv_idle_pct = 66;
        hold_off_req = 1'b0;
        items_sent = 0;
        i_rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.req_type <= REQ_APPEND;
        req_ch.position <= '0;
        req_ch.element <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Rejections on an empty list.
        send_request(REQ_GET, 7'd0, 32'd9);
        send_request(REQ_REMOVE, 7'd0, 32'd0);
        send_request(REQ_FIND, 7'd0, 32'd0);
        send_request(REQ_FIND, 7'd0, 32'd5);
        send_request(REQ_APPEND, 7'd0, 32'd0);
        send_request(REQ_INSERT, 7'd0, 32'd0);
        send_request(REQ_INSERT, 7'd1, 32'd5);
        send_request(REQ_SET, 7'd0, 32'd5);
        send_request(REQ_SET, 7'd0, 32'd0);
        // Building, reading and shrinking a short list, then an unused code and a clear.
        send_request(REQ_APPEND, 7'd127, 32'hFFFF_FFFF);
        send_request(REQ_APPEND, 7'd0, 32'd1);
        send_request(REQ_INSERT, 7'd0, 32'h8000_0000);
        send_request(REQ_INSERT, 7'd3, 32'h0000_0002);
        send_request(REQ_GET, 7'd127, 32'd0);
        send_request(REQ_GET, 7'd0, 32'd0);
        send_request(REQ_SET, 7'd1, 32'hAAAA_5555);
        send_request(REQ_FIND, 7'd0, 32'hAAAA_5555);
        send_request(REQ_FIND, 7'd0, 32'h1234_5678);
        send_request(REQ_REMOVE, 7'd0, 32'd0);
        send_request(REQ_REMOVE, 7'd2, 32'd0);
        send_request(REQ_UNUSED, 7'h7F, 32'hFFFF_FFFF);
        send_request(REQ_CLEAR, 7'd0, 32'd0);
        send_request(REQ_GET, 7'd0, 32'd0);
        send_request(REQ_APPEND, 7'd0, 32'h5555_AAAA);

        run_random(620, 21, 66, 1'b1);
        run_random(640, 66, 21, 1'b0);
        run_random(640, 0, 0, 1'b1);
        req_ch.valid <= 1'b0;

        while (sb.expected_rsp.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.total_failures() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/ilt_pkg.sv
rtl/ilt_if.sv
rtl/ilt_ram.sv
rtl/ilt_seq.sv
rtl/indexed_list_table_core.sv
rtl/ilt_checker.sv
tb/indexed_list_table_core_tb.sv
